/* hw/rtl/tksk_pkg.sv */
// Package for the top-k score keeper.
// Holds the mode codes, config constants and controller/datapath structs.
// No dependencies.
package tksk_pkg;

    // Input item operation codes
    localparam logic [1:0] MODE_OFFER = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // keep_count register
    localparam int         KEEP_W     = 5;
    localparam logic [4:0] KEEP_RESET = 5'd16;

    // Controller to datapath commands
    typedef struct packed {
        logic offer;     // insert the input tuple
        logic clear;     // empty all slots
        logic rd_start;  // rewind the readout index
        logic load;      // load the output register, advance the index
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic rd_last;   // readout index is at the final active slot
    } t_sts;

endpackage

/* hw/rtl/tksk_in_if.sv */
// Input channel interface of the top-k score keeper.
// Carries valid, ready and one offer/readout/clear item. No dependencies.
interface tksk_in_if #(
    parameter int FRAME_BITS = 16,
    parameter int SITE_BITS  = 16,
    parameter int SCORE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic [FRAME_BITS-1:0] frame_number;
    logic [SITE_BITS-1:0]  site_index;
    logic [SCORE_BITS-1:0] score;

    modport source (output valid, mode, frame_number, site_index, score, input ready);
    modport sink   (input valid, mode, frame_number, site_index, score, output ready);
endinterface

/* hw/rtl/tksk_out_if.sv */
// Result channel interface of the top-k score keeper.
// Carries valid, ready and one listed entry. No dependencies.
interface tksk_out_if #(
    parameter int FRAME_BITS = 16,
    parameter int SITE_BITS  = 16,
    parameter int SCORE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [FRAME_BITS-1:0] out_frame;
    logic [SITE_BITS-1:0]  out_site;
    logic [SCORE_BITS-1:0] out_score;
    logic                  occupied;
    logic                  last;

    modport source (output valid, out_frame, out_site, out_score, occupied, last,
                    input ready);
    modport sink   (input valid, out_frame, out_site, out_score, occupied, last,
                    output ready);
endinterface

/* hw/rtl/tksk_cfg_if.sv */
// Configuration write channel of the top-k score keeper.
// Carries valid, ready and the keep_count write data. Depends on tksk_pkg.
interface tksk_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tksk_pkg::KEEP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* hw/rtl/top_k_score_keeper_core.sv */
// Top-k score keeper core: keeps the keep_count best (frame, site, score)
// tuples in descending score order.
// Channels: i_in takes items (mode 0 offer, 1 read out, 2 clear, 3 ignored),
// o_out delivers readout entries, i_cfg writes keep_count (1..DEPTH; zero
// acts as one, larger values saturate at DEPTH). Write it only while idle.
// Offer and clear complete at the accepting edge: every active cell
// compares the offered score in parallel and shifts in the same cycle,
// so offers and clears stream at one item per cycle while no readout
// runs. A readout gives keep_count results (as clamped above), highest
// first, with occupied and last flags. After the transfer the controller
// enters its read state and then loads one slot per cycle into the
// output register while the receiver takes every result.
// While a readout runs i_in.ready is low.
// A stalled receiver holds the output register and pauses the readout;
// nothing is lost. An offer may be accepted while the final result waits.
// Reset (i_rst_n low, synchronous) empties the list at once and sets
// keep_count to 16. Depends on tksk_pkg, the interfaces, tksk_ctrl and
// tksk_datapath.
module top_k_score_keeper_core #(
    parameter int DEPTH      = 16,
    parameter int FRAME_BITS = 16,
    parameter int SITE_BITS  = 16,
    parameter int SCORE_BITS = 32
) (
    input logic  i_clk,
    input logic  i_rst_n,
    tksk_in_if.sink   i_in,
    tksk_out_if.source o_out,
    tksk_cfg_if.sink  i_cfg
);
    import tksk_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    tksk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_mode      (i_in.mode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    tksk_datapath #(
        .DEPTH      (DEPTH),
        .FRAME_BITS (FRAME_BITS),
        .SITE_BITS  (SITE_BITS),
        .SCORE_BITS (SCORE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_wr   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .i_frame    (i_in.frame_number),
        .i_site     (i_in.site_index),
        .i_score    (i_in.score),
        .o_frame    (o_out.out_frame),
        .o_site     (o_out.out_site),
        .o_score    (o_out.out_score),
        .o_occupied (o_out.occupied),
        .o_last     (o_out.last)
    );

endmodule

/* hw/rtl/tksk_ctrl.sv */
// Controller state machine of the top-k score keeper.
// Decodes input items, sequences readouts and owns the output valid flag. Depends on tksk_pkg.
module tksk_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_mode,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tksk_pkg::t_cmd o_cmd,
    input  tksk_pkg::t_sts i_sts
);
    import tksk_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic in_xfer;
    logic out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (i_mode)
                        MODE_OFFER: o_cmd.offer = 1'b1;
                        MODE_CLEAR: o_cmd.clear = 1'b1;
                        MODE_READ: begin
                            o_cmd.rd_start = 1'b1;
                            n_state        = ST_READ;
                        end
                        default: ;  // unused code: no effect
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.rd_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output valid: set on load, dropped on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* hw/rtl/tksk_datapath.sv */
// Datapath of the top-k score keeper: slot cells, keep_count register,
// parallel compare-and-shift insert, readout index and output register.
// Depends on tksk_pkg.
module tksk_datapath #(
    parameter int DEPTH      = 16,
    parameter int FRAME_BITS = 16,
    parameter int SITE_BITS  = 16,
    parameter int SCORE_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tksk_pkg::t_cmd              i_cmd,
    output tksk_pkg::t_sts              o_sts,
    input  logic                        i_cfg_wr,
    input  logic [tksk_pkg::KEEP_W-1:0] i_cfg_data,
    input  logic [FRAME_BITS-1:0]       i_frame,
    input  logic [SITE_BITS-1:0]        i_site,
    input  logic [SCORE_BITS-1:0]       i_score,
    output logic [FRAME_BITS-1:0]       o_frame,
    output logic [SITE_BITS-1:0]        o_site,
    output logic [SCORE_BITS-1:0]       o_score,
    output logic                        o_occupied,
    output logic                        o_last
);
    import tksk_pkg::*;

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((NW > KEEP_W) ? NW : KEEP_W) + 1;

    logic [KEEP_W-1:0]     r_keep;
    logic [NW-1:0]         act_n;
    logic [FRAME_BITS-1:0] r_frame [DEPTH];
    logic [SITE_BITS-1:0]  r_site  [DEPTH];
    logic [SCORE_BITS-1:0] r_score [DEPTH];
    logic [DEPTH-1:0]      r_used, n_used;
    logic [DEPTH-1:0]      used_dn;
    logic [DEPTH-1:0]      active;
    logic [DEPTH-1:0]      hit;
    logic [DEPTH-1:0]      below;
    logic [DEPTH-1:0]      ins;
    logic [DEPTH-1:0]      shift;
    logic [IW-1:0]         r_rd_idx;
    logic [FRAME_BITS-1:0] r_o_frame;
    logic [SITE_BITS-1:0]  r_o_site;
    logic [SCORE_BITS-1:0] r_o_score;
    logic                  r_o_occupied;
    logic                  r_o_last;

    // keep_count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= KEEP_RESET;
        end else if (i_cfg_wr) begin
            r_keep <= i_cfg_data;
        end
    end

    // Slots in use: zero means one, saturate at DEPTH
    always_comb begin
        if (r_keep == '0) begin
            act_n = NW'(1);
        end else if (CMPW'(r_keep) > CMPW'(DEPTH)) begin
            act_n = NW'(DEPTH);
        end else begin
            act_n = NW'(r_keep);
        end
    end

    // Per-cell compare; insert at first hit, shift cells past it
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            active[k] = CMPW'(k) < CMPW'(act_n);
            hit[k]    = active[k] && (!r_used[k] || (i_score > r_score[k]));
        end
        for (int k = 0; k < DEPTH; k++) begin
            below[k] = |(hit & DEPTH'((65'(1) << k) - 65'(1)));
            ins[k]   = hit[k] && !below[k];
            shift[k] = below[k] && active[k];
        end
    end

    assign used_dn = r_used << 1;

    // Used flags
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            if (i_cmd.clear) begin
                n_used[k] = 1'b0;
            end else if (i_cmd.offer && ins[k]) begin
                n_used[k] = 1'b1;
            end else if (i_cmd.offer && shift[k]) begin
                n_used[k] = used_dn[k];
            end else begin
                n_used[k] = r_used[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    // Slot payload cells
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [FRAME_BITS-1:0] prv_frame;
        logic [SITE_BITS-1:0]  prv_site;
        logic [SCORE_BITS-1:0] prv_score;

        if (k == 0) begin : g_head
            assign prv_frame = '0;
            assign prv_site  = '0;
            assign prv_score = '0;
        end else begin : g_body
            assign prv_frame = r_frame[k-1];
            assign prv_site  = r_site[k-1];
            assign prv_score = r_score[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.offer && ins[k]) begin
                r_frame[k] <= i_frame;
                r_site[k]  <= i_site;
                r_score[k] <= i_score;
            end else if (i_cmd.offer && shift[k]) begin
                r_frame[k] <= prv_frame;
                r_site[k]  <= prv_site;
                r_score[k] <= prv_score;
            end
        end
    end

    // Readout index
    assign o_sts.rd_last = (NW'(r_rd_idx) == (act_n - NW'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (i_cmd.rd_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.load) begin
            r_rd_idx <= r_rd_idx + IW'(1);
        end
    end

    // Output register; empty slots read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_frame    <= r_used[r_rd_idx] ? r_frame[r_rd_idx] : '0;
            r_o_site     <= r_used[r_rd_idx] ? r_site[r_rd_idx]  : '0;
            r_o_score    <= r_used[r_rd_idx] ? r_score[r_rd_idx] : '0;
            r_o_occupied <= r_used[r_rd_idx];
            r_o_last     <= o_sts.rd_last;
        end
    end

    assign o_frame    = r_o_frame;
    assign o_site     = r_o_site;
    assign o_score    = r_o_score;
    assign o_occupied = r_o_occupied;
    assign o_last     = r_o_last;

endmodule
